// ----- rtl/ebsn_pkg.sv -----
// Shared types, constants and helper functions for the ext2 superblock probe offset block.
// No dependencies; used by ebsn_step_unit and ext2_backup_superblock_next_offset.
package ebsn_pkg;

    localparam int IN_W = 48;
    localparam int OUT_W = 51;
    localparam int P_W = 28;
    localparam int K_W = 2;
    localparam int F_W = 2;

    localparam logic [OUT_W-1:0] MIN_BLOCK_BYTES = OUT_W'(1024);
    localparam logic [OUT_W-1:0] SB_PAD = OUT_W'(2 * 512);
    localparam int GRP_BASE_SHIFT = 23;

    localparam logic [K_W-1:0] BLK_FIRST = 2'd0;
    localparam logic [K_W-1:0] BLK_LAST = 2'd3;

    localparam logic [F_W-1:0] FAC_3 = 2'd0;
    localparam logic [F_W-1:0] FAC_5 = 2'd1;
    localparam logic [F_W-1:0] FAC_7 = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EDGE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OUT_W-1:0] cand;
        logic             le_prev;
        logic             lt_best;
        logic [P_W-1:0]   p_next;
    } t_step;

    function automatic logic [2:0] blk_shift(input logic [K_W-1:0] k);
        logic [2:0] s;
        case (k)
            2'd0:    s = 3'd0;
            2'd1:    s = 3'd1;
            2'd2:    s = 3'd2;
            default: s = 3'd6;
        endcase
        return s;
    endfunction

    function automatic logic [5:0] grp_shift(input logic [K_W-1:0] k);
        return 6'(GRP_BASE_SHIFT) + {2'b00, blk_shift(k), 1'b0};
    endfunction

    function automatic logic [OUT_W-1:0] blk_bytes(input logic [K_W-1:0] k);
        return MIN_BLOCK_BYTES << blk_shift(k);
    endfunction

endpackage

// ----- rtl/ebsn_step_unit.sv -----
// Shared arithmetic unit: forms one candidate offset, compares it, and scales the power.
// Depends on ebsn_pkg.
module ebsn_step_unit import ebsn_pkg::*; (
    input  logic [P_W-1:0]   i_p,
    input  logic [IN_W-1:0]  i_prev,
    input  logic [OUT_W-1:0] i_best,
    input  logic [K_W-1:0]   i_k,
    input  logic [F_W-1:0]   i_f,
    output t_step            o_step
);

    logic [OUT_W-1:0] shifted;
    logic [OUT_W-1:0] cand;
    logic [P_W+2:0]   p_wide;
    logic [P_W+2:0]   p_ext;

    always_comb begin
        shifted = {{(OUT_W-P_W){1'b0}}, i_p} << grp_shift(i_k);
        cand = (i_k == BLK_FIRST) ? (shifted | SB_PAD) : shifted;
        p_ext = {3'b000, i_p};
        case (i_f)
            FAC_3:   p_wide = p_ext + (p_ext << 1);
            FAC_5:   p_wide = p_ext + (p_ext << 2);
            FAC_7:   p_wide = (p_ext << 3) - p_ext;
            default: p_wide = p_ext;
        endcase
        o_step.cand = cand;
        o_step.le_prev = cand <= {{(OUT_W-IN_W){1'b0}}, i_prev};
        o_step.lt_best = cand < i_best;
        o_step.p_next = p_wide[P_W-1:0];
    end

endmodule

// ----- rtl/ext2_backup_superblock_next_offset.sv -----
// Top level: sequencer, operand registers and result register around ebsn_step_unit.
// Depends on ebsn_pkg and ebsn_step_unit.
//
// Returns the next byte offset above i_old_offset where an ext2 superblock or sparse
// backup may lie, for 1K, 2K, 4K and 64K blocks and backup groups at powers of 3, 5, 7.
// One item at a time: o_ready is high only while idle. One shared step unit tests one
// power per cycle; for each of the twelve size/factor pairs it tries powers until one
// lies above the old offset, then the boundary check runs and the result is held for
// the output transfer, so small offsets finish sooner. The next input transfer can
// follow once the block has returned to idle after the output transfer.
module ext2_backup_superblock_next_offset import ebsn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [IN_W-1:0]    i_old_offset,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [OUT_W-1:0]   o_next_offset
);

    t_state           r_state, n_state;
    logic [IN_W-1:0]  r_prev;
    logic [P_W-1:0]   r_p;
    logic [K_W-1:0]   r_k;
    logic [F_W-1:0]   r_f;
    logic [OUT_W-1:0] r_best;
    t_step            step;
    logic             pair_last;
    logic [OUT_W-1:0] edge_sel;

    ebsn_step_unit u_step (
        .i_p    (r_p),
        .i_prev (r_prev),
        .i_best (r_best),
        .i_k    (r_k),
        .i_f    (r_f),
        .o_step (step)
    );

    assign pair_last = (r_k == BLK_LAST) && (r_f == FAC_7);

    always_comb begin
        edge_sel = r_best;
        for (int i = 3; i >= 0; i--) begin
            if (({{(OUT_W-IN_W){1'b0}}, r_prev} < blk_bytes(K_W'(i)))
                    && (blk_bytes(K_W'(i)) < r_best)) begin
                edge_sel = blk_bytes(K_W'(i));
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SEARCH;
            S_SEARCH: if (!step.le_prev && pair_last) n_state = S_EDGE;
            S_EDGE:   n_state = S_DONE;
            S_DONE:   if (i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE:  o_ready = 1'b1;
            S_DONE:  o_valid = 1'b1;
            default: begin
                o_ready = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    assign o_next_offset = r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_prev <= i_old_offset;
                    r_p <= P_W'(1);
                    r_k <= BLK_FIRST;
                    r_f <= FAC_3;
                    r_best <= '1;
                end
            end
            S_SEARCH: begin
                if (step.le_prev) begin
                    r_p <= step.p_next;
                end else begin
                    if (step.lt_best) begin
                        r_best <= step.cand;
                    end
                    r_p <= P_W'(1);
                    if (r_f == FAC_7) begin
                        r_f <= FAC_3;
                        r_k <= r_k + K_W'(1);
                    end else begin
                        r_f <= r_f + F_W'(1);
                    end
                end
            end
            S_EDGE: r_best <= edge_sel;
            default: begin
            end
        endcase
    end

endmodule
